// ===== rtl/mqttfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mqttfd_pkg
// Types and constants shared by the MQTT frame deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mqttfd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned TOTAL_W = 29;
   localparam int unsigned ACCUM_W = 28;
   localparam int unsigned ERR_W   = 2;

   localparam logic [TOTAL_W-1:0] MAX_FRAME_RESET = 29'd268435460;

   localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
   localparam logic [ERR_W-1:0] ERR_OVERSIZE  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_MALFORMED = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0]  data_byte;
      logic               frame_start;
      logic               header_done;
      logic               frame_last;
      logic [TOTAL_W-1:0] frame_total;
      logic [ERR_W-1:0]   error_code;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/mqttfd_core.sv =====
// ----------------------------------------------------------------------------
// mqttfd_core
// Frame state tracker: decodes the fixed header, checks the total size and
// counts payload bytes down; gives the flags for the current byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mqttfd_core #(
   parameter int unsigned MAX_LENGTH_BYTES = 4
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            step,
   input  wire logic [7:0]                      rx_byte,
   input  wire logic [28:0]                     max_frame_size,
   output mqttfd_pkg::result_type               result
);
   import mqttfd_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_PAY  = 2'd2;

   localparam logic [2:0] LEN_LIMIT = 3'(MAX_LENGTH_BYTES);

   logic [1:0]         phase_ff, phase_in;
   logic [2:0]         hcount_ff, hcount_in;
   logic [ACCUM_W-1:0] accum_ff, accum_in;
   logic [TOTAL_W-1:0] left_ff, left_in;

   logic [6:0]         value7;
   logic [ACCUM_W-1:0] shifted;
   logic [ACCUM_W-1:0] accum_sum;
   logic [2:0]         hcount_inc;
   logic [TOTAL_W-1:0] total_sum;
   logic [1:0]         k;

   always_comb begin
      value7     = rx_byte[6:0];
      k          = 2'(hcount_ff - 3'd1);
      case (k)
         2'd0:    shifted = {21'd0, value7};
         2'd1:    shifted = {14'd0, value7, 7'd0};
         2'd2:    shifted = {7'd0, value7, 14'd0};
         2'd3:    shifted = {value7, 21'd0};
         default: shifted = '0;
      endcase
      accum_sum  = accum_ff + shifted;
      hcount_inc = hcount_ff + 3'd1;
      total_sum  = TOTAL_W'(accum_sum) + TOTAL_W'(hcount_inc);
   end

   always_comb begin
      phase_in  = phase_ff;
      hcount_in = hcount_ff;
      accum_in  = accum_ff;
      left_in   = left_ff;

      result.data_byte   = rx_byte;
      result.frame_start = 1'b0;
      result.header_done = 1'b0;
      result.frame_last  = 1'b0;
      result.frame_total = '0;
      result.error_code  = ERR_NONE;

      case (phase_ff)
         PH_LEN: begin
            accum_in  = accum_sum;
            hcount_in = hcount_inc;
            if (!rx_byte[7]) begin
               if (total_sum > max_frame_size) begin
                  result.error_code = ERR_OVERSIZE;
                  phase_in  = PH_IDLE;
                  hcount_in = '0;
                  accum_in  = '0;
                  left_in   = '0;
               end else begin
                  result.header_done = 1'b1;
                  result.frame_total = total_sum;
                  if (accum_sum == '0) begin
                     result.frame_last = 1'b1;
                     phase_in  = PH_IDLE;
                     hcount_in = '0;
                     accum_in  = '0;
                     left_in   = '0;
                  end else begin
                     left_in  = TOTAL_W'(accum_sum);
                     phase_in = PH_PAY;
                  end
               end
            end else if (hcount_ff >= LEN_LIMIT) begin
               result.error_code = ERR_MALFORMED;
               phase_in  = PH_IDLE;
               hcount_in = '0;
               accum_in  = '0;
               left_in   = '0;
            end
         end
         PH_PAY: begin
            if (left_ff <= TOTAL_W'(1)) begin
               result.frame_last = 1'b1;
               phase_in  = PH_IDLE;
               hcount_in = '0;
               accum_in  = '0;
               left_in   = '0;
            end else begin
               left_in = left_ff - TOTAL_W'(1);
            end
         end
         default: begin
            result.frame_start = 1'b1;
            phase_in  = PH_LEN;
            hcount_in = 3'd1;
            accum_in  = '0;
            left_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         hcount_ff <= '0;
         accum_ff  <= '0;
         left_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         hcount_ff <= hcount_in;
         accum_ff  <= accum_in;
         left_ff   <= left_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mqtt_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// mqtt_frame_deframer
// Splits a received byte stream into MQTT frames and tags each byte.
//
//   channel  ports                         direction  word
//   req      req_valid/req_stall           in         one received byte
//   rsp      rsp_valid/rsp_stall           out        byte with frame flags
//   csr      csr_write_en/csr_write_data   in         maximum frame size
//
// One byte per cycle unless rsp stalls; each result appears in the cycle after
// its byte is taken, via a single result register fed by the header/payload
// tracker. Reset (synchronous) returns to waiting for a type byte and sets
// the maximum to the largest frame total. A stall on rsp holds the result
// register and raises req_stall in the same cycle while a result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module mqtt_frame_deframer #(
   parameter int unsigned MAX_LENGTH_BYTES = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_frame_start,
   output logic             rsp_header_done,
   output logic             rsp_frame_last,
   output logic [28:0]      rsp_frame_total,
   output logic [1:0]       rsp_error_code,

   input  wire logic        csr_write_en,
   input  wire logic [28:0] csr_write_data
);
   import mqttfd_pkg::*;

   logic               accept;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] max_size_ff;
   result_type         result;
   result_type         out_ff;

   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   mqttfd_core #(
      .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (accept),
      .rx_byte        (req_rx_byte),
      .max_frame_size (max_size_ff),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         max_size_ff  <= MAX_FRAME_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            max_size_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_byte   = out_ff.data_byte;
   assign rsp_frame_start = out_ff.frame_start;
   assign rsp_header_done = out_ff.header_done;
   assign rsp_frame_last  = out_ff.frame_last;
   assign rsp_frame_total = out_ff.frame_total;
   assign rsp_error_code  = out_ff.error_code;

endmodule

`default_nettype wire

// ===== tb/tb_mqtt_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_mqtt_frame_deframer
// Checks the MQTT deframer byte for byte against a behavioral model of the
// header and payload tracker. A short table covers the type, length and
// payload paths, zero remaining length, the oversize and malformed-length
// errors and the extreme size limits. Random frames follow, with padded and
// oversized length fields, truncated headers and line noise, across several
// maximum frame sizes. Both sides idle in random bursts, the sink holds off
// once for a long stretch, and every word is compared field by field.
// ----------------------------------------------------------------------------
module tb_mqtt_frame_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   import mqttfd_pkg::*;

   localparam int MAX_LEN_BYTES = 4;
   localparam int RUN_LIMIT     = 200000;
   localparam int LONG_HOLD     = 300;
   localparam int PHASE_WORDS   = 100;

   typedef enum logic [1:0] {FR_IDLE, FR_LENGTH, FR_PAYLOAD} frame_phase_type;
   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [28:0]  value;
      bit           typed;
      result_type   res;
   } dir_row_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte    = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [7:0]  rsp_data_byte;
   logic        rsp_frame_start;
   logic        rsp_header_done;
   logic        rsp_frame_last;
   logic [28:0] rsp_frame_total;
   logic [1:0]  rsp_error_code;
   logic        csr_write_en   = 1'b0;
   logic [28:0] csr_write_data = '0;

   frame_phase_type fr_phase  = FR_IDLE;
   logic [2:0]      hdr_bytes = '0;
   logic [27:0]     rem_len   = '0;
   logic [28:0]     pay_left  = '0;
   logic [28:0]     max_frame = MAX_FRAME_RESET;

   result_type  tagged_byte_q[$];
   dir_row_type dir_rows[$];
   int          bad_words  = 0;
   int          items_sent = 0;
   int          stall_left = 0;
   int          hold_left  = 0;
   int unsigned cycle_cnt  = 0;
   bit          idle_on    = 1'b1;
   bit          hold_req   = 1'b0;

   mqtt_frame_deframer #(.MAX_LENGTH_BYTES(MAX_LEN_BYTES)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_frame_start (rsp_frame_start),
      .rsp_header_done (rsp_header_done),
      .rsp_frame_last  (rsp_frame_last),
      .rsp_frame_total (rsp_frame_total),
      .rsp_error_code  (rsp_error_code),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= RUN_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic void frame_reset_state();
      fr_phase  = FR_IDLE;
      hdr_bytes = '0;
      rem_len   = '0;
      pay_left  = '0;
   endfunction

   function automatic result_type deframe_byte(input logic [7:0] b);
      result_type  r;
      logic [28:0] tot;
      int          shift;
      r = '0;
      r.data_byte = b;
      case (fr_phase)
         FR_LENGTH: begin
            shift = 7 * ((int'(hdr_bytes) - 1) & 3);
            rem_len = rem_len + (28'(b[6:0]) << shift);
            hdr_bytes = hdr_bytes + 3'd1;
            if (!b[7]) begin
               tot = 29'(rem_len) + 29'(hdr_bytes);
               if (tot > max_frame) begin
                  r.error_code = ERR_OVERSIZE;
                  frame_reset_state();
               end else begin
                  r.header_done = 1'b1;
                  r.frame_total = tot;
                  if (rem_len == '0) begin
                     r.frame_last = 1'b1;
                     frame_reset_state();
                  end else begin
                     pay_left = 29'(rem_len);
                     fr_phase = FR_PAYLOAD;
                  end
               end
            end else if (int'(hdr_bytes) - 1 >= MAX_LEN_BYTES) begin
               r.error_code = ERR_MALFORMED;
               frame_reset_state();
            end
         end
         FR_PAYLOAD: begin
            if (pay_left <= 29'd1) begin
               r.frame_last = 1'b1;
               frame_reset_state();
            end else begin
               pay_left = pay_left - 29'd1;
            end
         end
         default: begin
            r.frame_start = 1'b1;
            fr_phase  = FR_LENGTH;
            hdr_bytes = 3'd1;
            rem_len   = '0;
            pay_left  = '0;
         end
      endcase
      return r;
   endfunction

   function automatic void report(input string what, input result_type want,
                                  input result_type got);
      bad_words++;
      if (bad_words <= 10) begin
         $display("%s: exp byte=%02h st=%0d hd=%0d last=%0d total=%0d err=%0d",
                  what, want.data_byte, want.frame_start, want.header_done,
                  want.frame_last, want.frame_total, want.error_code);
         $display("%s: got byte=%02h st=%0d hd=%0d last=%0d total=%0d err=%0d",
                  what, got.data_byte, got.frame_start, got.header_done,
                  got.frame_last, got.frame_total, got.error_code);
      end
   endfunction

   always @(posedge clock) begin : rsp_side
      result_type got;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.data_byte   = rsp_data_byte;
         got.frame_start = rsp_frame_start;
         got.header_done = rsp_header_done;
         got.frame_last  = rsp_frame_last;
         got.frame_total = rsp_frame_total;
         got.error_code  = rsp_error_code;
         if (tagged_byte_q.size() == 0) begin
            report("unexpected word", '0, got);
         end else begin
            want = tagged_byte_q.pop_front();
            if (got.data_byte !== want.data_byte || got.frame_start !== want.frame_start ||
                got.header_done !== want.header_done ||
                got.frame_last !== want.frame_last ||
                got.frame_total !== want.frame_total ||
                got.error_code !== want.error_code)
               report("word mismatch", want, got);
         end
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 16) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic put(input logic [7:0] b, input bit typed = 1'b0,
                      input result_type res = '0);
      result_type tag;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      tag = deframe_byte(b);
      tagged_byte_q.push_back(typed ? res : tag);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (tagged_byte_q.size() != 0);
   endtask

   task automatic write_max(input logic [28:0] value);
      drain();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      max_frame = value;
   endtask

   task automatic send_frame(input logic [27:0] len, input bit pad);
      int          n;
      int          i;
      logic [28:0] tot;
      n = len < 28'd128 ? 1 : len < 28'd16384 ? 2 : len < 28'd2097152 ? 3 : 4;
      if (pad) n = $urandom_range(n, MAX_LEN_BYTES);
      tot = 29'(len) + 29'(n + 1);
      put(8'($urandom));
      for (i = 0; i < n; i++)
         put(8'((len >> (7 * i)) & 28'h7F) | (i < n - 1 ? 8'h80 : 8'h00));
      if (tot <= max_frame)
         for (i = 0; i < int'(len); i++) put(8'($urandom));
   endtask

   task automatic gen_sequence();
      int          sel;
      logic [27:0] len;
      // finish whatever noise left open
      while (fr_phase != FR_IDLE)
         put(fr_phase == FR_LENGTH ? 8'($urandom) | 8'h80 : 8'($urandom));
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
         send_frame(28'($urandom_range(0, 48)), $urandom_range(0, 3) == 0);
      end else if (sel < 80) begin
         len = 28'($urandom) >> $urandom_range(0, 21);
         if (29'(len) + 29'd2 > max_frame) send_frame(len, 1'b0);
         else send_frame(28'($urandom_range(0, 48)), 1'b0);
      end else if (sel < 90) begin
         put(8'($urandom));
         repeat (MAX_LEN_BYTES) put(8'($urandom) | 8'h80);
      end else begin
         repeat ($urandom_range(1, 6))
            put(fr_phase == FR_LENGTH && hdr_bytes >= 3'd2 ?
                8'($urandom) | 8'h80 : 8'($urandom));
      end
   endtask

   function automatic dir_row_type row_b(input logic [7:0] b);
      dir_row_type r;
      r.kind  = ROW_BYTE;
      r.value = 29'(b);
      r.typed = 1'b0;
      r.res   = '0;
      return r;
   endfunction

   function automatic dir_row_type row_x(input logic [7:0] b, input logic st, input logic hd,
                                         input logic last, input logic [28:0] total,
                                         input logic [1:0] err);
      dir_row_type r;
      r = row_b(b);
      r.typed           = 1'b1;
      r.res.data_byte   = b;
      r.res.frame_start = st;
      r.res.header_done = hd;
      r.res.frame_last  = last;
      r.res.frame_total = total;
      r.res.error_code  = err;
      return r;
   endfunction

   function automatic dir_row_type row_c(input logic [28:0] value);
      dir_row_type r;
      r = row_b(8'h00);
      r.kind  = ROW_CSR;
      r.value = value;
      return r;
   endfunction

   initial begin
      logic [28:0] lim;
      int          stop;
      dir_rows.push_back(row_x(8'h00, 1, 0, 0, 0, ERR_NONE));
      dir_rows.push_back(row_x(8'h00, 0, 1, 1, 2, ERR_NONE));
      dir_rows.push_back(row_x(8'hFF, 1, 0, 0, 0, ERR_NONE));
      dir_rows.push_back(row_x(8'h02, 0, 1, 0, 4, ERR_NONE));
      dir_rows.push_back(row_b(8'hA5));
      dir_rows.push_back(row_x(8'h5A, 0, 0, 1, 0, ERR_NONE));
      dir_rows.push_back(row_b(8'h30));
      dir_rows.push_back(row_b(8'h80));
      dir_rows.push_back(row_b(8'h80));
      dir_rows.push_back(row_b(8'h80));
      dir_rows.push_back(row_x(8'h80, 0, 0, 0, 0, ERR_MALFORMED));
      dir_rows.push_back(row_c(29'd268435459));
      dir_rows.push_back(row_b(8'h10));
      dir_rows.push_back(row_b(8'hFF));
      dir_rows.push_back(row_b(8'hFF));
      dir_rows.push_back(row_b(8'hFF));
      dir_rows.push_back(row_x(8'h7F, 0, 0, 0, 0, ERR_OVERSIZE));
      dir_rows.push_back(row_c(29'd2));
      dir_rows.push_back(row_b(8'h20));
      dir_rows.push_back(row_x(8'h00, 0, 1, 1, 2, ERR_NONE));
      dir_rows.push_back(row_b(8'h21));
      dir_rows.push_back(row_x(8'h01, 0, 0, 0, 0, ERR_OVERSIZE));
      dir_rows.push_back(row_c(29'd0));
      dir_rows.push_back(row_b(8'hE0));
      dir_rows.push_back(row_x(8'h00, 0, 0, 0, 0, ERR_OVERSIZE));
      dir_rows.push_back(row_c(29'h1FFFFFFF));
      dir_rows.push_back(row_b(8'hC0));
      dir_rows.push_back(row_b(8'h80));
      dir_rows.push_back(row_b(8'h01));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) write_max(dir_rows[i].value);
         else put(dir_rows[i].value[7:0], dir_rows[i].typed, dir_rows[i].res);
      end

      for (int p = 0; p < 5; p++) begin
         case (p)
            0:       lim = 29'($urandom_range(2, 60));
            1:       lim = MAX_FRAME_RESET;
            2:       lim = 29'd2;
            3:       lim = 29'h1FFFFFFF;
            default: lim = 29'($urandom_range(30, 120));
         endcase
         write_max(lim);
         // hold the sink off while bytes keep coming
         if (p == 1) hold_req = 1'b1;
         if (p == 4) idle_on = 1'b0;
         stop = items_sent + PHASE_WORDS;
         while (items_sent < stop) gen_sequence();
      end

      drain();
      repeat (4) @(posedge clock);
      if (bad_words == 0 && tagged_byte_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/mqttfd_pkg.sv
rtl/mqttfd_core.sv
rtl/mqtt_frame_deframer.sv
tb/tb_mqtt_frame_deframer.sv
